[hw/rtl/bss_pkg.sv]
// ----------------------------------------------------------------------------
// bss_pkg
// Shared constants for the byte signature scanner: window size, signature
// byte strings and match flag positions.
// ----------------------------------------------------------------------------
`default_nettype none

package bss_pkg;

  // Default window size: current byte plus WINDOW_BYTES-1 bytes of history
  localparam int unsigned WindowBytesDefault = 16;

  // Longest signature, sets the minimum history depth
  localparam int unsigned MaxSigLen = 16;

  // Signature lengths
  localparam int unsigned SyscallLen = 2;
  localparam int unsigned PebLen     = 9;
  localparam int unsigned AesLen     = 16;
  localparam int unsigned PopCount   = 6;

  // CLD/CALL/POP positions in history at the time the trailing byte arrives
  localparam int unsigned CldSlot    = 6;
  localparam int unsigned CallSlot   = 5;
  localparam int unsigned PopSlot    = 0;
  localparam int unsigned CldMinFill = 7;

  // Signature bytes, first byte of each signature at index 0
  localparam logic [7:0] SYSCALL_SIG [SyscallLen] = '{8'h0F, 8'h05};

  localparam logic [7:0] PEB_SIG [PebLen] = '{
    8'h65, 8'h48, 8'h8B, 8'h04, 8'h25, 8'h60, 8'h00, 8'h00, 8'h00
  };

  localparam logic [7:0] AES_SIG [AesLen] = '{
    8'h63, 8'h7C, 8'h77, 8'h7B, 8'hF2, 8'h6B, 8'h6F, 8'hC5,
    8'h30, 8'h01, 8'h67, 8'h2B, 8'hFE, 8'hD7, 8'hAB, 8'h76
  };

  localparam logic [7:0] POP_OPS [PopCount] = '{
    8'h58, 8'h59, 8'h5A, 8'h5B, 8'h5E, 8'h5F
  };

  localparam logic [7:0] CLD_OP  = 8'hFC;
  localparam logic [7:0] CALL_OP = 8'hE8;

  // Match flag bit positions
  localparam int unsigned FlagCld = 0;
  localparam int unsigned FlagSys = 1;
  localparam int unsigned FlagPeb = 2;
  localparam int unsigned FlagAes = 3;
  localparam int unsigned NumFlags = 4;

endpackage

`default_nettype wire

[hw/rtl/bss_byte_if.sv]
// ----------------------------------------------------------------------------
// bss_byte_if
// Valid/ready channel carrying one region byte and its last-of-region flag.
// ----------------------------------------------------------------------------
`default_nettype none

interface bss_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_of_region;

  modport source (output valid, output data_byte, output last_of_region, input ready);
  modport sink   (input valid, input data_byte, input last_of_region, output ready);
endinterface

`default_nettype wire

[hw/rtl/bss_result_if.sv]
// ----------------------------------------------------------------------------
// bss_result_if
// Valid/ready channel carrying the per-region signature flags.
// ----------------------------------------------------------------------------
`default_nettype none

interface bss_result_if;
  logic valid;
  logic ready;
  logic found_cld_call_pop;
  logic found_syscall;
  logic found_gs_load;
  logic found_sbox_head;
  logic any_found;

  modport source (
    output valid, output found_cld_call_pop, output found_syscall,
    output found_gs_load, output found_sbox_head, output any_found, input ready
  );
  modport sink (
    input valid, input found_cld_call_pop, input found_syscall,
    input found_gs_load, input found_sbox_head, input any_found, output ready
  );
endinterface

`default_nettype wire

[hw/rtl/byte_signature_scanner_top.sv]
// ----------------------------------------------------------------------------
// byte_signature_scanner_top
// Scans the bytes of a region for four fixed signatures and reports sticky
// match flags on the last byte of the region.
// ----------------------------------------------------------------------------
//
//   Channel | Dir | Payload                                  | Item
//   --------+-----+------------------------------------------+-----------------
//   in_i    | in  | data_byte[7:0], last_of_region           | one region byte
//   out_o   | out | found_cld_call_pop, found_syscall,       | one per region,
//           |     | found_gs_load, found_sbox_head, any_found| on last byte
//
// One byte per clock, sustained while a region's last byte finds room in the
// result register. A byte is registered on accept and compared against all
// signatures in the following cycle; on the last byte the flags load into the
// result register once it has room, and the result is offered from there.
// Reset clears the fill count, flags and valid bits; history needs none since
// the fill count gates every slot. A stalled result holds only the last byte
// of the next region; bytes before it keep flowing.
// ----------------------------------------------------------------------------
`default_nettype none

module byte_signature_scanner_top #(
  parameter int unsigned WINDOW_BYTES = bss_pkg::WindowBytesDefault
) (
  input  wire          clk_i,
  input  wire          rst_ni,
  bss_byte_if.sink     in_i,
  bss_result_if.source out_o
);

  localparam int unsigned HistLen = WINDOW_BYTES - 1;
  localparam int unsigned FillW   = $clog2(WINDOW_BYTES + 1);

  // Input register
  logic       s1_valid_q;
  logic [7:0] s1_byte_q;
  logic       s1_last_q;
  logic       s1_adv;

  // Scan state
  logic [7:0]                  hist_q [HistLen];
  logic [FillW-1:0]            fill_q;
  logic [bss_pkg::NumFlags-1:0] flags_q, flags_d;

  // Result register
  logic                         out_valid_q;
  logic [bss_pkg::NumFlags-1:0] res_flags_q;

  // Match terms
  logic hit_sys, hit_peb, hit_aes, hit_cld, is_pop;

  // A non-last byte always advances; a last byte needs room in the result reg
  assign s1_adv    = s1_valid_q && (!s1_last_q || !out_valid_q || out_o.ready);
  assign in_i.ready = !s1_valid_q || s1_adv;

  // Capture input byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      s1_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      s1_byte_q <= in_i.data_byte;
      s1_last_q <= in_i.last_of_region;
    end
  end

  // Compare the current byte and history against every signature
  always_comb begin
    hit_sys = (fill_q >= FillW'(bss_pkg::SyscallLen - 1))
           && (s1_byte_q == bss_pkg::SYSCALL_SIG[1])
           && (hist_q[0] == bss_pkg::SYSCALL_SIG[0]);

    hit_peb = (fill_q >= FillW'(bss_pkg::PebLen - 1))
           && (s1_byte_q == bss_pkg::PEB_SIG[bss_pkg::PebLen-1]);
    for (int j = 0; j < int'(bss_pkg::PebLen) - 1; j++) begin
      if (hist_q[j] != bss_pkg::PEB_SIG[int'(bss_pkg::PebLen) - 2 - j]) hit_peb = 1'b0;
    end

    hit_aes = (fill_q >= FillW'(bss_pkg::AesLen - 1))
           && (s1_byte_q == bss_pkg::AES_SIG[bss_pkg::AesLen-1]);
    for (int j = 0; j < int'(bss_pkg::AesLen) - 1; j++) begin
      if (hist_q[j] != bss_pkg::AES_SIG[int'(bss_pkg::AesLen) - 2 - j]) hit_aes = 1'b0;
    end

    is_pop = 1'b0;
    for (int k = 0; k < int'(bss_pkg::PopCount); k++) begin
      if (hist_q[bss_pkg::PopSlot] == bss_pkg::POP_OPS[k]) is_pop = 1'b1;
    end

    hit_cld = (fill_q >= FillW'(bss_pkg::CldMinFill))
           && (hist_q[bss_pkg::CldSlot] == bss_pkg::CLD_OP)
           && (hist_q[bss_pkg::CallSlot] == bss_pkg::CALL_OP)
           && is_pop;

    flags_d = flags_q;
    flags_d[bss_pkg::FlagCld] = flags_q[bss_pkg::FlagCld] | hit_cld;
    flags_d[bss_pkg::FlagSys] = flags_q[bss_pkg::FlagSys] | hit_sys;
    flags_d[bss_pkg::FlagPeb] = flags_q[bss_pkg::FlagPeb] | hit_peb;
    flags_d[bss_pkg::FlagAes] = flags_q[bss_pkg::FlagAes] | hit_aes;
  end

  // Advance fill count and flags; clear both at the end of a region
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q  <= '0;
      flags_q <= '0;
    end else if (s1_adv) begin
      if (s1_last_q) begin
        fill_q  <= '0;
        flags_q <= '0;
      end else begin
        flags_q <= flags_d;
        if (fill_q < FillW'(WINDOW_BYTES)) begin
          fill_q <= fill_q + FillW'(1);
        end
      end
    end
  end

  // Shift history, newest byte in slot zero
  always_ff @(posedge clk_i) begin
    if (s1_adv && !s1_last_q) begin
      hist_q[0] <= s1_byte_q;
      for (int j = 1; j < int'(HistLen); j++) begin
        hist_q[j] <= hist_q[j-1];
      end
    end
  end

  // Result register: load on last byte, drop when taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv && s1_last_q) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && s1_last_q) begin
      res_flags_q <= flags_d;
    end
  end

  assign out_o.valid              = out_valid_q;
  assign out_o.found_cld_call_pop = res_flags_q[bss_pkg::FlagCld];
  assign out_o.found_syscall      = res_flags_q[bss_pkg::FlagSys];
  assign out_o.found_gs_load      = res_flags_q[bss_pkg::FlagPeb];
  assign out_o.found_sbox_head    = res_flags_q[bss_pkg::FlagAes];
  assign out_o.any_found          = |res_flags_q;

endmodule

`default_nettype wire
